// ----- rtl/mrp_pkg.sv -----
// Package for the free-rectangle packer: sizes, the free rectangle record and
// shared constants. No dependencies.
package mrp_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIM_BITS   = 13;
   localparam int MAX_FREE   = 256;
   localparam int ADDR_BITS  = $clog2(MAX_FREE);
   localparam int CNT_BITS   = ADDR_BITS + 1;
   localparam int EXT_BITS   = COORD_BITS + 1;
   localparam int AREA_BITS  = 2 * EXT_BITS;
   localparam int RECT_BITS  = 4 * COORD_BITS;

   localparam logic [COORD_BITS-1:0] PLANE_MAX = {COORD_BITS{1'b1}};

   // One free rectangle; x1 and y1 are exclusive.
   typedef struct packed {
      logic [COORD_BITS-1:0] x0;
      logic [COORD_BITS-1:0] y0;
      logic [COORD_BITS-1:0] x1;
      logic [COORD_BITS-1:0] y1;
   } frect_type;

endpackage

// ----- rtl/mrp_req_if.sv -----
// Request channel of the packer: one rectangle per item.
// Depends on mrp_pkg.
interface mrp_req_if import mrp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                start_job;
   logic [DIM_BITS-1:0] rect_width;
   logic [DIM_BITS-1:0] rect_height;

   modport source (output valid, start_job, rect_width, rect_height, input ready);
   modport sink   (input valid, start_job, rect_width, rect_height, output ready);
endinterface

// ----- rtl/mrp_rsp_if.sv -----
// Response channel of the packer: placement and atlas size per item.
// Depends on mrp_pkg.
interface mrp_rsp_if import mrp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic [COORD_BITS-1:0] atlas_width;
   logic [COORD_BITS-1:0] atlas_height;
   logic                  list_overflow;
   logic                  no_fit;

   modport source (output valid, pos_x, pos_y, atlas_width, atlas_height, list_overflow,
                   no_fit, input ready);
   modport sink   (input valid, pos_x, pos_y, atlas_width, atlas_height, list_overflow,
                   no_fit, output ready);
endinterface

// ----- rtl/mrp_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mrp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/maxrects_rectangle_packer.sv -----
// Free-rectangle packer: places each rectangle in the cheapest fitting free rectangle.
// Per item: scan the free list for a spot, split each overlapped free rectangle, then
// run the containment pass over the list; one item at a time, bounded by the single
// read port of the free list memory.
// Reset: S_INIT writes the whole plane into entry zero; count and extents return to one.
// Depends on mrp_pkg, mrp_req_if, mrp_rsp_if and mrp_ram.
module maxrects_rectangle_packer import mrp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [COORD_BITS-1:0] csr_wr_data,
   mrp_req_if.sink               req_if,
   mrp_rsp_if.source             rsp_if
);

   typedef enum logic [12:0] {
      S_INIT    = 13'b0000000000001,
      S_IDLE    = 13'b0000000000010,
      S_RESTART = 13'b0000000000100,
      S_SCAN    = 13'b0000000001000,
      S_SP_RD   = 13'b0000000010000,
      S_SP_CHK  = 13'b0000000100000,
      S_SP_MOV  = 13'b0000001000000,
      S_SP_PUSH = 13'b0000010000000,
      S_CT_RD   = 13'b0000100000000,
      S_CT_P    = 13'b0001000000000,
      S_CT_SCAN = 13'b0010000000000,
      S_CT_MOV  = 13'b0100000000000,
      S_DONE    = 13'b1000000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [COORD_BITS-1:0] cfg_side_ff, cfg_side_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] canvas_w_ff, canvas_w_in, canvas_h_ff, canvas_h_in;
   logic [COORD_BITS-1:0] ext_w_ff, ext_w_in, ext_h_ff, ext_h_in;
   logic [DIM_BITS-1:0]   rw_ff, rw_in, rh_ff, rh_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in, jiss_ff, jiss_in;
   logic                  rv_ff, rv_in;
   logic [ADDR_BITS-1:0]  rj_ff, rj_in;
   logic                  a_v_ff, a_v_in, b_v_ff, b_v_in;
   logic [EXT_BITS-1:0]   a_right_ff, a_right_in, a_bot_ff, a_bot_in;
   logic [EXT_BITS-1:0]   a_mw_ff, a_mw_in, a_mh_ff, a_mh_in;
   logic [COORD_BITS-1:0] a_x0_ff, a_x0_in, a_y0_ff, a_y0_in;
   logic [AREA_BITS-1:0]  b_area_ff, b_area_in;
   logic [EXT_BITS-1:0]   b_right_ff, b_right_in, b_bot_ff, b_bot_in;
   logic [COORD_BITS-1:0] b_x0_ff, b_x0_in, b_y0_ff, b_y0_in;
   logic                  found_ff, found_in;
   logic [AREA_BITS-1:0]  best_area_ff, best_area_in;
   logic [EXT_BITS-1:0]   best_right_ff, best_right_in, best_bot_ff, best_bot_in;
   logic [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic                  ovf_ff, ovf_in;
   frect_type             r_ff, r_in;
   logic [3:0]            pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [COORD_BITS-1:0] rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;
   logic                  rsp_ovf_ff, rsp_ovf_in, rsp_nofit_ff, rsp_nofit_in;

   logic                  wr_en, rd_en;
   logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
   logic [RECT_BITS-1:0]  wr_data, rd_data;
   frect_type             rd_rect, piece;
   logic [CNT_BITS-1:0]   idx_m1, cnt_m1;
   logic [COORD_BITS-1:0] qx1, qy1;
   logic                  req_take, rsp_load, better, overlap, contained;
   logic [EXT_BITS-1:0]   s_right, s_bot;

   assign rd_rect = frect_type'(rd_data);
   assign idx_m1  = idx_ff - 1'b1;
   assign cnt_m1  = cnt_ff - 1'b1;
   assign qx1     = best_right_ff[COORD_BITS-1:0];
   assign qy1     = best_bot_ff[COORD_BITS-1:0];

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.pos_x         = rsp_x_ff;
   assign rsp_if.pos_y         = rsp_y_ff;
   assign rsp_if.atlas_width   = rsp_w_ff;
   assign rsp_if.atlas_height  = rsp_h_ff;
   assign rsp_if.list_overflow = rsp_ovf_ff;
   assign rsp_if.no_fit        = rsp_nofit_ff;

   // Free list memory.
   mrp_ram #(.WIDTH(RECT_BITS), .DEPTH(MAX_FREE)) u_free_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Scan pipeline arithmetic on the entry just read.
   assign s_right = {1'b0, rd_rect.x0} + EXT_BITS'(rw_ff);
   assign s_bot   = {1'b0, rd_rect.y0} + EXT_BITS'(rh_ff);

   // Cost ordering: area, then bottom edge, then right edge; earlier entry wins ties.
   assign better = !found_ff || (b_area_ff < best_area_ff) ||
                   ((b_area_ff == best_area_ff) && ((b_bot_ff < best_bot_ff) ||
                   ((b_bot_ff == best_bot_ff) && (b_right_ff < best_right_ff))));

   // Does the free rectangle read now overlap the placed one?
   assign overlap = !((px_ff >= rd_rect.x1) || (py_ff >= rd_rect.y1) ||
                      (qx1 <= rd_rect.x0) || (qy1 <= rd_rect.y0));

   // Is the held rectangle inside the one read now?
   assign contained = (r_ff.x0 >= rd_rect.x0) && (r_ff.y0 >= rd_rect.y0) &&
                      (r_ff.x1 <= rd_rect.x1) && (r_ff.y1 <= rd_rect.y1);

   // Split piece for the lowest pending side: left, top, right, bottom.
   always_comb begin
      piece = r_ff;
      priority if (pend_ff[0]) begin
         piece.x1 = px_ff;
      end else if (pend_ff[1]) begin
         piece.y1 = py_ff;
      end else if (pend_ff[2]) begin
         piece.x0 = qx1;
      end else begin
         piece.y0 = qy1;
      end
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in      = state_ff;
      cfg_side_in   = csr_wr_en ? csr_wr_data : cfg_side_ff;
      cnt_in        = cnt_ff;
      canvas_w_in   = canvas_w_ff;
      canvas_h_in   = canvas_h_ff;
      ext_w_in      = ext_w_ff;
      ext_h_in      = ext_h_ff;
      rw_in         = rw_ff;
      rh_in         = rh_ff;
      idx_in        = idx_ff;
      jiss_in       = jiss_ff;
      rv_in         = 1'b0;
      rj_in         = rj_ff;
      a_v_in        = 1'b0;
      a_right_in    = s_right;
      a_bot_in      = s_bot;
      a_mw_in       = (s_right > {1'b0, canvas_w_ff}) ? s_right : {1'b0, canvas_w_ff};
      a_mh_in       = (s_bot > {1'b0, canvas_h_ff}) ? s_bot : {1'b0, canvas_h_ff};
      a_x0_in       = rd_rect.x0;
      a_y0_in       = rd_rect.y0;
      b_v_in        = 1'b0;
      b_area_in     = AREA_BITS'(a_mw_ff) * AREA_BITS'(a_mh_ff);
      b_right_in    = a_right_ff;
      b_bot_in      = a_bot_ff;
      b_x0_in       = a_x0_ff;
      b_y0_in       = a_y0_ff;
      found_in      = found_ff;
      best_area_in  = best_area_ff;
      best_right_in = best_right_ff;
      best_bot_in   = best_bot_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      ovf_in        = ovf_ff;
      r_in          = r_ff;
      pend_in       = pend_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_m1[ADDR_BITS-1:0];
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[ADDR_BITS-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_nofit_in  = rsp_nofit_ff;

      unique case (state_ff)
         S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {{(2*COORD_BITS){1'b0}}, PLANE_MAX, PLANE_MAX};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_take) begin
               rw_in    = req_if.rect_width;
               rh_in    = req_if.rect_height;
               found_in = 1'b0;
               px_in    = '0;
               py_in    = '0;
               ovf_in   = 1'b0;
               idx_in   = '0;
               state_in = req_if.start_job ? S_RESTART : S_SCAN;
            end
         end
         S_RESTART: begin
            wr_en       = 1'b1;
            wr_addr     = '0;
            wr_data     = {{(2*COORD_BITS){1'b0}}, PLANE_MAX, PLANE_MAX};
            cnt_in      = CNT_BITS'(1);
            canvas_w_in = cfg_side_ff;
            canvas_h_in = cfg_side_ff;
            ext_w_in    = COORD_BITS'(1);
            ext_h_in    = COORD_BITS'(1);
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            // Stream reads of the list through the fit, area and compare stages.
            if (idx_ff < cnt_ff) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + 1'b1;
               rv_in  = 1'b1;
            end
            a_v_in = rv_ff && (s_right <= {1'b0, rd_rect.x1}) && (s_bot <= {1'b0, rd_rect.y1});
            b_v_in = a_v_ff;
            if (b_v_ff && better) begin
               found_in      = 1'b1;
               best_area_in  = b_area_ff;
               best_bot_in   = b_bot_ff;
               best_right_in = b_right_ff;
               px_in         = b_x0_ff;
               py_in         = b_y0_ff;
            end
            if ((idx_ff >= cnt_ff) && !rv_ff && !a_v_ff && !b_v_ff) begin
               if (found_ff) begin
                  canvas_w_in = (qx1 > canvas_w_ff) ? qx1 : canvas_w_ff;
                  canvas_h_in = (qy1 > canvas_h_ff) ? qy1 : canvas_h_ff;
                  ext_w_in    = (qx1 > ext_w_ff) ? qx1 : ext_w_ff;
                  ext_h_in    = (qy1 > ext_h_ff) ? qy1 : ext_h_ff;
                  idx_in      = cnt_ff;
                  state_in    = S_SP_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SP_RD: begin
            if (idx_ff == '0) begin
               idx_in   = cnt_ff;
               state_in = S_CT_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_m1[ADDR_BITS-1:0];
               state_in = S_SP_CHK;
            end
         end
         S_SP_CHK: begin
            r_in = rd_rect;
            if (!overlap) begin
               idx_in   = idx_m1;
               state_in = S_SP_RD;
            end else begin
               // Remove the entry: fetch the last one to fill its slot.
               cnt_in   = cnt_m1;
               rd_en    = 1'b1;
               rd_addr  = cnt_m1[ADDR_BITS-1:0];
               pend_in  = {qy1 < rd_rect.y1, qx1 < rd_rect.x1,
                           py_ff > rd_rect.y0, px_ff > rd_rect.x0};
               state_in = S_SP_MOV;
            end
         end
         S_SP_MOV: begin
            wr_en    = 1'b1;
            state_in = S_SP_PUSH;
         end
         S_SP_PUSH: begin
            if (pend_ff == '0) begin
               idx_in   = idx_m1;
               state_in = S_SP_RD;
            end else begin
               if (cnt_ff < CNT_BITS'(MAX_FREE)) begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[ADDR_BITS-1:0];
                  wr_data = piece;
                  cnt_in  = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               pend_in = pend_ff & (pend_ff - 1'b1);
            end
         end
         S_CT_RD: begin
            if (idx_ff == '0) begin
               state_in = S_DONE;
            end else if (idx_m1 >= cnt_ff) begin
               idx_in = idx_m1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_m1[ADDR_BITS-1:0];
               state_in = S_CT_P;
            end
         end
         S_CT_P: begin
            r_in     = rd_rect;
            jiss_in  = '0;
            state_in = S_CT_SCAN;
         end
         S_CT_SCAN: begin
            if (rv_ff && (rj_ff != idx_m1[ADDR_BITS-1:0]) && contained) begin
               cnt_in   = cnt_m1;
               rd_en    = 1'b1;
               rd_addr  = cnt_m1[ADDR_BITS-1:0];
               state_in = S_CT_MOV;
            end else if (jiss_ff < cnt_ff) begin
               rd_en   = 1'b1;
               rd_addr = jiss_ff[ADDR_BITS-1:0];
               rj_in   = jiss_ff[ADDR_BITS-1:0];
               jiss_in = jiss_ff + 1'b1;
               rv_in   = 1'b1;
            end else if (!rv_ff) begin
               idx_in   = idx_m1;
               state_in = S_CT_RD;
            end
         end
         S_CT_MOV: begin
            wr_en    = 1'b1;
            idx_in   = idx_m1;
            state_in = S_CT_RD;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = px_ff;
               rsp_y_in     = py_ff;
               rsp_w_in     = ext_w_ff;
               rsp_h_in     = ext_h_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_nofit_in = !found_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cfg_side_ff  <= '0;
         cnt_ff       <= CNT_BITS'(1);
         canvas_w_ff  <= '0;
         canvas_h_ff  <= '0;
         ext_w_ff     <= COORD_BITS'(1);
         ext_h_ff     <= COORD_BITS'(1);
         rv_ff        <= 1'b0;
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_side_ff  <= cfg_side_in;
         cnt_ff       <= cnt_in;
         canvas_w_ff  <= canvas_w_in;
         canvas_h_ff  <= canvas_h_in;
         ext_w_ff     <= ext_w_in;
         ext_h_ff     <= ext_h_in;
         rv_ff        <= rv_in;
         a_v_ff       <= a_v_in;
         b_v_ff       <= b_v_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rw_ff         <= rw_in;
      rh_ff         <= rh_in;
      idx_ff        <= idx_in;
      jiss_ff       <= jiss_in;
      rj_ff         <= rj_in;
      a_right_ff    <= a_right_in;
      a_bot_ff      <= a_bot_in;
      a_mw_ff       <= a_mw_in;
      a_mh_ff       <= a_mh_in;
      a_x0_ff       <= a_x0_in;
      a_y0_ff       <= a_y0_in;
      b_area_ff     <= b_area_in;
      b_right_ff    <= b_right_in;
      b_bot_ff      <= b_bot_in;
      b_x0_ff       <= b_x0_in;
      b_y0_ff       <= b_y0_in;
      best_area_ff  <= best_area_in;
      best_right_ff <= best_right_in;
      best_bot_ff   <= best_bot_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      r_ff          <= r_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_h_ff      <= rsp_h_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_nofit_ff  <= rsp_nofit_in;
   end

   // The free count never passes the list depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_FREE))
      else $error("free count above list depth");

   // A result without a placement never reports dropped pieces.
   a_nofit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nofit_ff) |-> !rsp_ovf_ff)
      else $error("no_fit result with overflow set");

   // An accepted item starts the search at once.
   a_take_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_SCAN || state_ff == S_RESTART))
      else $error("accepted item did not start");

   // A finished item shows up on the result register.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result load lost");

endmodule

// ----- tb/mrp_checker.sv -----
// Checker for the rectangle packer: watches both channels and the CSR port,
// predicts every placement and compares it with the returned item.
// Depends on mrp_pkg, mrp_req_if and mrp_rsp_if.
module mrp_checker import mrp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [COORD_BITS-1:0] csr_wr_data,
   mrp_req_if                    req_if,
   mrp_rsp_if                    rsp_if,
   output int unsigned           error_count,
   output int unsigned           pending
);

   typedef struct packed {
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0] atlas_width;
      logic [COORD_BITS-1:0] atlas_height;
      logic                  list_overflow;
      logic                  no_fit;
   } placement_type;

   // Shadow of the packer state.
   frect_type             free_list [MAX_FREE];
   int unsigned           free_len;
   int unsigned           canvas_w, canvas_h, extent_w, extent_h;
   logic [COORD_BITS-1:0] canvas_side;
   placement_type         placements_q[$];

   function automatic void restart_job();
      free_list[0] = '{x0: '0, y0: '0, x1: PLANE_MAX, y1: PLANE_MAX};
      free_len     = 1;
      canvas_w     = canvas_side;
      canvas_h     = canvas_side;
      extent_w     = 1;
      extent_h     = 1;
   endfunction

   function automatic bit add_piece(int unsigned x0, int unsigned y0,
                                    int unsigned x1, int unsigned y1);
      if (free_len >= MAX_FREE) return 1'b0;
      free_list[free_len] = '{x0: x0[COORD_BITS-1:0], y0: y0[COORD_BITS-1:0],
                              x1: x1[COORD_BITS-1:0], y1: y1[COORD_BITS-1:0]};
      free_len++;
      return 1'b1;
   endfunction

   function automatic void drop_entry(int unsigned idx);
      free_len--;
      free_list[idx] = free_list[free_len];
   endfunction

   // Best-fit search, split of overlapped free rectangles, then pruning.
   function automatic placement_type place_rect(bit start, int unsigned w, int unsigned h);
      placement_type     res;
      bit                found, ovf;
      longint unsigned   best_area, area;
      int unsigned       best_bot, best_right, px, py, right, bot, qx1, qy1, a;
      frect_type         r, p, q;
      found = 0; ovf = 0; best_area = 0; best_bot = 0; best_right = 0; px = 0; py = 0;
      if (start) restart_job();
      for (int unsigned i = 0; i < free_len; i++) begin
         r     = free_list[i];
         right = r.x0 + w;
         bot   = r.y0 + h;
         if (right > r.x1 || bot > r.y1) continue;
         area = longint'(canvas_w > right ? canvas_w : right) *
                longint'(canvas_h > bot ? canvas_h : bot);
         if (!found || area < best_area || (area == best_area &&
             (bot < best_bot || (bot == best_bot && right < best_right)))) begin
            found = 1; best_area = area; best_bot = bot; best_right = right;
            px = r.x0; py = r.y0;
         end
      end
      if (found) begin
         qx1 = px + w;
         qy1 = py + h;
         if (qx1 > canvas_w) canvas_w = qx1;
         if (qy1 > canvas_h) canvas_h = qy1;
         if (qx1 > extent_w) extent_w = qx1;
         if (qy1 > extent_h) extent_h = qy1;
         // Replace every overlapped free rectangle by its leftover pieces.
         for (int unsigned i = free_len; i > 0; i--) begin
            r = free_list[i-1];
            if (px >= r.x1 || py >= r.y1 || qx1 <= r.x0 || qy1 <= r.y0) continue;
            drop_entry(i-1);
            if (px > r.x0 && !add_piece(r.x0, r.y0, px, r.y1)) ovf = 1;
            if (py > r.y0 && !add_piece(r.x0, r.y0, r.x1, py)) ovf = 1;
            if (qx1 < r.x1 && !add_piece(qx1, r.y0, r.x1, r.y1)) ovf = 1;
            if (qy1 < r.y1 && !add_piece(r.x0, qy1, r.x1, r.y1)) ovf = 1;
         end
         // Drop free rectangles that lie inside another one.
         for (int unsigned i = free_len; i > 0; i--) begin
            a = i - 1;
            if (a >= free_len) continue;
            for (int unsigned j = 0; j < free_len; j++) begin
               p = free_list[a];
               q = free_list[j];
               if (j != a && p.x0 >= q.x0 && p.y0 >= q.y0 && p.x1 <= q.x1 &&
                   p.y1 <= q.y1) begin
                  drop_entry(a);
                  break;
               end
            end
         end
      end
      res.pos_x         = px[COORD_BITS-1:0];
      res.pos_y         = py[COORD_BITS-1:0];
      res.atlas_width   = extent_w[COORD_BITS-1:0];
      res.atlas_height  = extent_h[COORD_BITS-1:0];
      res.list_overflow = ovf;
      res.no_fit        = !found;
      return res;
   endfunction

   // Predict on each accepted request, compare on each accepted response.
   always @(posedge clock) begin
      placement_type want, got;
      if (reset) begin
         canvas_side = '0;
         restart_job();
         placements_q.delete();
         error_count = 0;
      end else begin
         if (csr_wr_en) canvas_side = csr_wr_data;
         if (req_if.valid && req_if.ready)
            placements_q.insert(placements_q.size(),
                                place_rect(req_if.start_job, req_if.rect_width,
                                           req_if.rect_height));
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.pos_x, rsp_if.pos_y, rsp_if.atlas_width, rsp_if.atlas_height,
                    rsp_if.list_overflow, rsp_if.no_fit};
            if (placements_q.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("Unexpected item on response channel");
            end else begin
               want = placements_q.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("Mismatch: expected x=%0d y=%0d w=%0d h=%0d ovf=%0b nofit=%0b",
                              want.pos_x, want.pos_y, want.atlas_width, want.atlas_height,
                              want.list_overflow, want.no_fit);
                     $display("          got      x=%0d y=%0d w=%0d h=%0d ovf=%0b nofit=%0b",
                              got.pos_x, got.pos_y, got.atlas_width, got.atlas_height,
                              got.list_overflow, got.no_fit);
                  end
               end
            end
         end
      end
      pending = placements_q.size();
   end

endmodule

// ----- tb/tb_maxrects_rectangle_packer.sv -----
// Top of the packer testbench: clock, reset, stimulus, response stalls and
// the verdict. Depends on mrp_pkg, both channel interfaces, the packer and mrp_checker.
module tb_maxrects_rectangle_packer;
   import mrp_pkg::*;

   localparam int CYCLE_LIMIT = 100000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [COORD_BITS-1:0] csr_wr_data = '0;
   int unsigned           error_count, pending, cycle_count = 0;
   int unsigned           stall_left = 0;
   bit                    quiet = 1'b0;

   mrp_req_if req_if ();
   mrp_rsp_if rsp_if ();

   maxrects_rectangle_packer i_dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_if(req_if), .rsp_if(rsp_if)
   );

   mrp_checker i_checker (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_if(req_if), .rsp_if(rsp_if), .error_count(error_count), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.start_job = 1'b0;
      req_if.rect_width = '0;
      req_if.rect_height = '0;
      rsp_if.ready = 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Response stalls come in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Sends one rectangle and waits for it to be taken, then maybe idles.
   task automatic send_rect(bit start, logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
      req_if.valid       <= 1'b1;
      req_if.start_job   <= start;
      req_if.rect_width  <= w;
      req_if.rect_height <= h;
      do @(posedge clock); while (!req_if.ready);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every placement has come back.
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_side(logic [COORD_BITS-1:0] side);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= side;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly mid sizes, sometimes tiny, sometimes any value of the full range.
   function automatic logic [DIM_BITS-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return DIM_BITS'($urandom_range(0, 8191));
         1, 2:    return DIM_BITS'($urandom_range(1, 16));
         default: return DIM_BITS'($urandom_range(1, 4096));
      endcase
   endfunction

   initial begin
      int unsigned job_len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, zero sizes and restarts.
      send_rect(1'b1, 13'd1, 13'd1);
      send_rect(1'b0, 13'd4096, 13'd4096);
      send_rect(1'b0, 13'd0, 13'd5);
      send_rect(1'b0, 13'd5, 13'd0);
      send_rect(1'b0, 13'd0, 13'd0);
      send_rect(1'b0, 13'd8191, 13'd8191);
      send_rect(1'b0, 13'd1, 13'd8191);
      write_side(16'hFFFF);
      send_rect(1'b1, 13'd8191, 13'd1);
      send_rect(1'b0, 13'd4096, 13'd1);
      send_rect(1'b0, 13'd2730, 13'd5461);
      write_side(16'd300);
      send_rect(1'b1, 13'd100, 13'd200);
      send_rect(1'b0, 13'd200, 13'd100);
      send_rect(1'b0, 13'd300, 13'd300);
      send_rect(1'b1, 13'd1, 13'd1);

      // Fill the plane with the largest squares until nothing fits.
      write_side(16'd0);
      for (int i = 0; i < 66; i++) send_rect(i == 0, 13'd8191, 13'd8191);

      // Sender holds off until all placements are back.
      drain();

      // Random jobs with occasional new canvas sides.
      for (int n = 0; n < 200; n += job_len) begin
         if ($urandom_range(0, 3) == 0)
            case ($urandom_range(0, 3))
               0:       write_side(16'd0);
               1:       write_side(16'hFFFF);
               default: write_side(COORD_BITS'($urandom_range(0, 65535)));
            endcase
         job_len = $urandom_range(1, 20);
         if (n > 160) quiet = 1'b1;
         for (int k = 0; k < job_len; k++)
            send_rect(k == 0 || $urandom_range(0, 30) == 0, pick_dim(), pick_dim());
      end

      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
